### rtl/timed_resend_priority_queue_defines.svh
// Assertion macros for the resend queue checker.
`ifndef TIMED_RESEND_PRIORITY_QUEUE_DEFINES_SVH
`define TIMED_RESEND_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define TRPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/trpq_pkg.sv
`timescale 1ns / 1ps

package trpq_pkg;

    localparam int SEQ_W      = 32;
    localparam int HANDLE_IN_W = 16;
    localparam int TIME_IN_W  = 48;
    localparam int NODE_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int WAIT_W     = 16;
    localparam int DLY_W      = 25;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 4;

    localparam int SD_SEQ_LSB    = 0;
    localparam int SD_HANDLE_LSB = 32;
    localparam int SD_TIME_LSB   = 48;

    localparam int MD_HANDLE_LSB = 0;
    localparam int MD_EMPTY      = 16;
    localparam int MD_TIME_LSB   = 17;
    localparam int MD_COUNT_LSB  = 65;

    localparam int MU_RELEASED = 0;
    localparam int MU_ADDED    = 1;
    localparam int MU_SKIP     = 2;
    localparam int MU_DROP     = 3;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SENDERS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_WAIT  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIST,
        ST_MUL,
        ST_SUM,
        ST_INS,
        ST_POLL,
        ST_RES
    } t_state;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    typedef struct packed {
        logic [SIZE_W-1:0] sender;
        logic [SIZE_W-1:0] me;
    } t_mod_res;

endpackage

### rtl/trpq_cell.sv
`timescale 1ns / 1ps

module trpq_cell import trpq_pkg::*; #(
    parameter int KEY_W       = 48,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [KEY_W-1:0]       i_new_key,
    input  logic [HANDLE_BITS-1:0] i_new_handle,
    input  logic                   i_left_valid,
    input  logic                   i_left_keep,
    input  logic [KEY_W-1:0]       i_left_key,
    input  logic [HANDLE_BITS-1:0] i_left_handle,
    input  logic                   i_right_valid,
    input  logic [KEY_W-1:0]       i_right_key,
    input  logic [HANDLE_BITS-1:0] i_right_handle,
    output logic                   o_valid,
    output logic                   o_keep,
    output logic [KEY_W-1:0]       o_key,
    output logic [HANDLE_BITS-1:0] o_handle
);

    logic                   r_valid, n_valid;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic                   keep;

    always_comb begin
        keep     = r_valid && (r_key <= i_new_key);
        n_valid  = r_valid;
        n_key    = r_key;
        n_handle = r_handle;
        priority if (i_ctl.pop) begin
            n_valid  = i_right_valid;
            n_key    = i_right_key;
            n_handle = i_right_handle;
        end else if (i_ctl.ins && !keep && i_left_keep) begin
            n_valid  = 1'b1;
            n_key    = i_new_key;
            n_handle = i_new_handle;
        end else if (i_ctl.ins && !keep) begin
            n_valid  = i_left_valid;
            n_key    = i_left_key;
            n_handle = i_left_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_valid  = r_valid;
    assign o_keep   = keep;
    assign o_key    = r_key;
    assign o_handle = r_handle;

endmodule

### rtl/trpq_mod.sv
`timescale 1ns / 1ps

module trpq_mod import trpq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEQ_W-1:0]  i_seq,
    input  logic [NODE_W-1:0] i_node,
    input  logic [SIZE_W-1:0] i_size,
    output logic              o_busy,
    output t_mod_res          o_res
);

    localparam int STEP_W = $clog2(SEQ_W);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [NODE_W-1:0] r_node, n_node;
    logic [SIZE_W-1:0] r_rs, n_rs;
    logic [SIZE_W-1:0] r_rm, n_rm;
    logic [SIZE_W-1:0] modulus;
    logic              node_bit;

    function automatic logic [SIZE_W-1:0] mod_step(input logic [SIZE_W-1:0] rem,
                                                   input logic bit_in,
                                                   input logic [SIZE_W-1:0] m);
        logic [SIZE_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[SIZE_W-1:0];
    endfunction

    always_comb begin
        modulus  = (i_size == '0) ? SIZE_W'(1) : i_size;
        node_bit = (r_cnt < STEP_W'(NODE_W)) ? r_node[NODE_W-1] : 1'b0;
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_seq    = r_seq;
        n_node   = r_node;
        n_rs     = r_rs;
        n_rm     = r_rm;
        priority if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(SEQ_W - 1);
            n_seq  = i_seq;
            n_node = i_node;
            n_rs   = '0;
            n_rm   = '0;
        end else if (r_busy) begin
            n_rs  = mod_step(r_rs, r_seq[SEQ_W-1], modulus);
            n_rm  = mod_step(r_rm, node_bit, modulus);
            n_seq = {r_seq[SEQ_W-2:0], 1'b0};
            if (r_cnt < STEP_W'(NODE_W)) begin
                n_node = {r_node[NODE_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq  <= n_seq;
        r_node <= n_node;
        r_rs   <= n_rs;
        r_rm   <= n_rm;
    end

    assign o_busy       = r_busy;
    assign o_res.sender = r_rs;
    assign o_res.me     = r_rm;

endmodule

### rtl/timed_resend_priority_queue.sv
`timescale 1ns / 1ps
// Resend scheduler: a queue of message handles sorted by due send time.
// Input words (s_axis): tuser selects add (0) or poll (1); tdata carries the
// sequence number, the message handle and the present time. Each input word
// gives exactly one output word (m_axis) with release/add/skip/drop flags in
// tuser and the released handle, empty flag, next due time and entry count
// in tdata. The user writes registers through i_cfg_we/i_cfg_idx/i_cfg_data
// only while the block is idle; the block does not enforce this. They take
// effect on the next word. A poll passes the poll and result states; an add
// passes remainder, distance, multiply, sum, insert and result (skip and
// drop go from multiply to result), waiting in remainder for the bit-serial
// remainder unit to work through the 32-bit sequence number. One word is
// in flight at a time. The queue is a row of QUEUE_DEPTH cells; an insert
// or a release updates every cell together, shifting entries to a neighbor.
// Reset (synchronous, active low) empties the queue and loads the register
// defaults. When the receiver stalls, the output word holds; one more input
// word is taken and worked up to its result, which then waits for the slot.

module timed_resend_priority_queue import trpq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 48,
    parameter int HANDLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // seq_num, message_handle, current_time
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // released_handle, queue_empty, next_send_time, pending_count, 2 zero bits
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // released, added, not_my_turn, full_drop
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int KEY_W = (TIME_BITS >= DLY_W) ? TIME_BITS : DLY_W + 1;
    localparam int SUM_W = KEY_W + 1;
    localparam int NOW_W = (TIME_BITS < TIME_IN_W) ? TIME_BITS : TIME_IN_W;
    localparam logic [SUM_W-1:0] TMASK = SUM_W'((65'd1 << TIME_BITS) - 65'd1);

    logic [NODE_W-1:0] r_node_id;
    logic [SIZE_W-1:0] r_network_size;
    logic [SIZE_W-1:0] r_max_senders;
    logic [WAIT_W-1:0] r_resend_wait;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_req, n_req;
    logic [SEQ_W-1:0]       r_seq, n_seq;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [KEY_W-1:0]       r_now, n_now;
    logic [SIZE_W-1:0]      r_dist, n_dist;
    logic [DLY_W-1:0]       r_delay, n_delay;
    logic [KEY_W-1:0]       r_when, n_when;
    logic                   r_rel, n_rel;
    logic [HANDLE_BITS-1:0] r_rel_handle, n_rel_handle;
    logic                   r_added, n_added;
    logic                   r_skip, n_skip;
    logic                   r_drop, n_drop;
    logic                   r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data, n_out_data;
    logic [M_TUSER_W-1:0]   r_out_user, n_out_user;

    logic                   accept;
    logic                   out_free;
    logic                   mod_start;
    logic                   mod_busy;
    t_mod_res               mod_res;
    logic [SIZE_W-1:0]      modulus;
    logic [SIZE_W:0]        dist_wide;
    logic [SUM_W-1:0]       sum;
    t_cell_ctl              cell_ctl;

    logic [QUEUE_DEPTH-1:0] c_valid;
    logic [QUEUE_DEPTH-1:0] c_keep;
    logic [KEY_W-1:0]       c_key    [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0] c_handle [QUEUE_DEPTH];

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign mod_start = accept && (s_axis_tuser == REQ_ADD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id      <= NODE_W'(0);
            r_network_size <= SIZE_W'(4);
            r_max_senders  <= SIZE_W'(3);
            r_resend_wait  <= WAIT_W'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_ID:      r_node_id      <= i_cfg_data[NODE_W-1:0];
                CFG_NETWORK_SIZE: r_network_size <= i_cfg_data[SIZE_W-1:0];
                CFG_MAX_SENDERS:  r_max_senders  <= i_cfg_data[SIZE_W-1:0];
                CFG_RESEND_WAIT:  r_resend_wait  <= i_cfg_data[WAIT_W-1:0];
            endcase
        end
    end

    trpq_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_seq   (s_axis_tdata[SD_SEQ_LSB +: SEQ_W]),
        .i_node  (r_node_id),
        .i_size  (r_network_size),
        .o_busy  (mod_busy),
        .o_res   (mod_res)
    );

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                   left_valid, left_keep, right_valid;
        logic [KEY_W-1:0]       left_key, right_key;
        logic [HANDLE_BITS-1:0] left_handle, right_handle;

        if (i == 0) begin : g_head
            assign left_valid  = 1'b0;
            assign left_keep   = 1'b1;
            assign left_key    = '0;
            assign left_handle = '0;
        end else begin : g_mid
            assign left_valid  = c_valid[i-1];
            assign left_keep   = c_keep[i-1];
            assign left_key    = c_key[i-1];
            assign left_handle = c_handle[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_valid  = 1'b0;
            assign right_key    = '0;
            assign right_handle = '0;
        end else begin : g_body
            assign right_valid  = c_valid[i+1];
            assign right_key    = c_key[i+1];
            assign right_handle = c_handle[i+1];
        end

        trpq_cell #(
            .KEY_W       (KEY_W),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (cell_ctl),
            .i_new_key      (r_when),
            .i_new_handle   (r_handle),
            .i_left_valid   (left_valid),
            .i_left_keep    (left_keep),
            .i_left_key     (left_key),
            .i_left_handle  (left_handle),
            .i_right_valid  (right_valid),
            .i_right_key    (right_key),
            .i_right_handle (right_handle),
            .o_valid        (c_valid[i]),
            .o_keep         (c_keep[i]),
            .o_key          (c_key[i]),
            .o_handle       (c_handle[i])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_req        = r_req;
        n_seq        = r_seq;
        n_handle     = r_handle;
        n_now        = r_now;
        n_dist       = r_dist;
        n_delay      = r_delay;
        n_when       = r_when;
        n_rel        = r_rel;
        n_rel_handle = r_rel_handle;
        n_added      = r_added;
        n_skip       = r_skip;
        n_drop       = r_drop;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        cell_ctl     = '0;
        modulus      = (r_network_size == '0) ? SIZE_W'(1) : r_network_size;
        dist_wide    = (mod_res.me >= mod_res.sender)
                     ? {1'b0, mod_res.me} - {1'b0, mod_res.sender}
                     : {1'b0, mod_res.me} + {1'b0, modulus} - {1'b0, mod_res.sender};
        sum          = SUM_W'(r_now) + SUM_W'(r_delay);
        s_axis_tready = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req        = s_axis_tuser;
                    n_seq        = s_axis_tdata[SD_SEQ_LSB +: SEQ_W];
                    n_handle     = HANDLE_BITS'(s_axis_tdata[SD_HANDLE_LSB +: HANDLE_IN_W]);
                    n_now        = KEY_W'(s_axis_tdata[SD_TIME_LSB +: NOW_W]);
                    n_rel        = 1'b0;
                    n_rel_handle = '0;
                    n_added      = 1'b0;
                    n_skip       = 1'b0;
                    n_drop       = 1'b0;
                    n_state      = (s_axis_tuser == REQ_POLL) ? ST_POLL : ST_MOD;
                end
            end
            ST_MOD: begin
                if (!mod_busy) begin
                    n_state = ST_DIST;
                end
            end
            ST_DIST: begin
                n_dist  = dist_wide[SIZE_W-1:0];
                n_state = ST_MUL;
            end
            ST_MUL: begin
                priority if (r_dist > r_max_senders) begin
                    n_skip  = 1'b1;
                    n_state = ST_RES;
                end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                    n_drop  = 1'b1;
                    n_state = ST_RES;
                end else begin
                    n_delay = DLY_W'(r_dist) * DLY_W'(r_resend_wait);
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if ((SUM_W'(r_delay) <= TMASK) && (sum > TMASK)) begin
                    n_when = TMASK[KEY_W-1:0];
                end else begin
                    n_when = sum[KEY_W-1:0];
                end
                n_state = ST_INS;
            end
            ST_INS: begin
                cell_ctl.ins = 1'b1;
                n_count      = r_count + CNT_W'(1);
                n_added      = 1'b1;
                n_state      = ST_RES;
            end
            ST_POLL: begin
                if (c_valid[0] && (c_key[0] <= r_now)) begin
                    cell_ctl.pop = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                    n_rel        = 1'b1;
                    n_rel_handle = c_handle[0];
                end
                n_state = ST_RES;
            end
            ST_RES: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00,
                                   CNT_OUT_W'(r_count),
                                   c_valid[0] ? TIME_IN_W'(c_key[0]) : TIME_IN_W'(0),
                                   (r_count == '0),
                                   HANDLE_IN_W'(r_rel_handle)};
                    n_out_user  = {r_drop, r_skip, r_added, r_rel};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_seq        <= n_seq;
        r_handle     <= n_handle;
        r_now        <= n_now;
        r_dist       <= n_dist;
        r_delay      <= n_delay;
        r_when       <= n_when;
        r_rel        <= n_rel;
        r_rel_handle <= n_rel_handle;
        r_added      <= n_added;
        r_skip       <= n_skip;
        r_drop       <= n_drop;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

### rtl/trpq_chk.sv
`timescale 1ns / 1ps
`include "timed_resend_priority_queue_defines.svh"

module trpq_chk import trpq_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    `TRPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
    `TRPQ_ASSERT_NOW(a_one_flag, i_clk, i_rst_n, m_axis_tvalid, $onehot0(m_axis_tuser), "more than one outcome flag")
    `TRPQ_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[MD_EMPTY], (m_axis_tdata[MD_TIME_LSB +: TIME_IN_W] == '0) && (m_axis_tdata[MD_COUNT_LSB +: CNT_OUT_W] == '0), "empty queue reports a time or a count")
    `TRPQ_ASSERT_NOW(a_added_nonempty, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[MU_ADDED], !m_axis_tdata[MD_EMPTY], "queue empty after an add")
    `TRPQ_ASSERT_NOW(a_handle_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[MU_RELEASED], m_axis_tdata[MD_HANDLE_LSB +: HANDLE_IN_W] == '0, "handle set without release")

endmodule

bind timed_resend_priority_queue trpq_chk u_trpq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/timed_resend_priority_queue_checker.sv
`timescale 1ns / 1ps

module timed_resend_priority_queue_checker import trpq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // seq_num, message_handle, current_time
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // req_type
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // released_handle, queue_empty, next_send_time, pending_count, 2 zero bits
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    // released, added, not_my_turn, full_drop
    input  logic [M_TUSER_W-1:0] i_m_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_open_count,
    output int                   o_released_n,
    output int                   o_skipped_n,
    output int                   o_dropped_n
);

    localparam int          DEPTH    = 16;
    localparam logic [63:0] TIME_MAX = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        released;
        logic [15:0] rel_handle;
        logic        added;
        logic        skipped;
        logic        dropped;
        logic        empty;
        logic [47:0] next_time;
        logic [4:0]  count;
    } resend_result_t;

    logic [47:0]    slot_time [DEPTH];
    logic [15:0]    slot_handle [DEPTH];
    int             slot_total;
    logic [7:0]     node_id_r;
    logic [8:0]     net_size_r;
    logic [8:0]     max_dist_r;
    logic [15:0]    wait_r;
    resend_result_t owed_results [$];
    int             reports;

    function automatic resend_result_t schedule_word(logic req, logic [31:0] seq,
                                                     logic [15:0] hnd, logic [47:0] now);
        resend_result_t r;
        logic [31:0]    m;
        logic [31:0]    sender;
        logic [31:0]    me;
        logic [31:0]    hops;
        logic [63:0]    delay;
        logic [63:0]    when;
        int             pos;
        r = '0;
        if (req == REQ_ADD) begin
            m      = (net_size_r == '0) ? 32'd1 : {23'd0, net_size_r};
            sender = seq % m;
            me     = {24'd0, node_id_r} % m;
            hops   = (me + m - sender) % m;
            if (hops > {23'd0, max_dist_r}) begin
                r.skipped = 1'b1;
            end else if (slot_total >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                delay = {32'd0, hops} * {48'd0, wait_r};
                if ({16'd0, now} > TIME_MAX - delay) begin
                    when = TIME_MAX;
                end else begin
                    when = {16'd0, now} + delay;
                end
                pos = 0;
                while (pos < slot_total && {16'd0, slot_time[pos]} <= when) pos++;
                for (int i = slot_total; i > pos; i--) begin
                    slot_time[i]   = slot_time[i-1];
                    slot_handle[i] = slot_handle[i-1];
                end
                slot_time[pos]   = when[47:0];
                slot_handle[pos] = hnd;
                slot_total++;
                r.added = 1'b1;
            end
        end else if (slot_total != 0 && slot_time[0] <= now) begin
            r.released   = 1'b1;
            r.rel_handle = slot_handle[0];
            for (int i = 1; i < slot_total; i++) begin
                slot_time[i-1]   = slot_time[i];
                slot_handle[i-1] = slot_handle[i];
            end
            slot_total--;
        end
        r.empty     = (slot_total == 0);
        r.next_time = (slot_total != 0) ? slot_time[0] : '0;
        r.count     = slot_total[4:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        resend_result_t seen;
        resend_result_t want;
        resend_result_t fresh;
        if (!i_rst_n) begin
            node_id_r  = 8'd0;
            net_size_r = 9'd4;
            max_dist_r = 9'd3;
            wait_r     = 16'd1000;
            slot_total = 0;
            owed_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NODE_ID:      node_id_r  = i_cfg_data[7:0];
                    CFG_NETWORK_SIZE: net_size_r = i_cfg_data[8:0];
                    CFG_MAX_SENDERS:  max_dist_r = i_cfg_data[8:0];
                    CFG_RESEND_WAIT:  wait_r     = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.released   = i_m_tuser[MU_RELEASED];
                seen.rel_handle = i_m_tdata[MD_HANDLE_LSB +: 16];
                seen.added      = i_m_tuser[MU_ADDED];
                seen.skipped    = i_m_tuser[MU_SKIP];
                seen.dropped    = i_m_tuser[MU_DROP];
                seen.empty      = i_m_tdata[MD_EMPTY];
                seen.next_time  = i_m_tdata[MD_TIME_LSB +: 48];
                seen.count      = i_m_tdata[MD_COUNT_LSB +: 5];
                if (owed_results.size() == 0) begin
                    o_fail_count++;
                    if (reports < 10)
                        $display("%0t: result word with no request outstanding: %p", $time, seen);
                    reports++;
                end else begin
                    want = owed_results.pop_front();
                    if (seen.released !== want.released || seen.rel_handle !== want.rel_handle
                        || seen.added !== want.added || seen.skipped !== want.skipped
                        || seen.dropped !== want.dropped || seen.empty !== want.empty
                        || seen.next_time !== want.next_time || seen.count !== want.count) begin
                        o_fail_count++;
                        if (reports < 10) begin
                            $display("%0t: mismatch, expected %p", $time, want);
                            $display("%0t:           actual   %p", $time, seen);
                        end
                        reports++;
                    end
                    if (want.released) o_released_n++;
                    if (want.skipped) o_skipped_n++;
                    if (want.dropped) o_dropped_n++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fresh = schedule_word(i_s_tuser,
                                      i_s_tdata[SD_SEQ_LSB +: 32],
                                      i_s_tdata[SD_HANDLE_LSB +: 16],
                                      i_s_tdata[SD_TIME_LSB +: 48]);
                owed_results = {owed_results, fresh};
            end
        end
        o_open_count = owed_results.size();
    end

endmodule

### tb/timed_resend_priority_queue_test.sv
`timescale 1ns / 1ps

module timed_resend_priority_queue_test;
    import trpq_pkg::*;

    localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    logic s_fire = 1'b0;
    logic m_fire = 1'b0;
    bit   idle_on;
    int   fail_count, open_count, released_n, skipped_n, dropped_n;
    int   words_n, adds_n, polls_n, settings_n;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        m_fire <= m_axis_tvalid && m_axis_tready;
    end

    timed_resend_priority_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    timed_resend_priority_queue_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_open_count (open_count),
        .o_released_n (released_n),
        .o_skipped_n  (skipped_n),
        .o_dropped_n  (dropped_n)
    );

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic put_word(logic req, logic [31:0] seq, logic [15:0] hnd, logic [47:0] now);
        int                   gap;
        logic [S_TDATA_W-1:0] payload;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        payload = '0;
        payload[SD_SEQ_LSB +: 32]    = seq;
        payload[SD_HANDLE_LSB +: 16] = hnd;
        payload[SD_TIME_LSB +: 48]   = now;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= payload;
        do @(negedge i_clk); while (!s_fire);
        words_n++;
        if (req == REQ_ADD) adds_n++;
        else polls_n++;
    endtask

    task automatic drain_queue();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (open_count != 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_registers(logic [15:0] d_node, logic [15:0] d_size,
                                 logic [15:0] d_max, logic [15:0] d_wait);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NODE_ID;
        i_cfg_data <= d_node;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_NETWORK_SIZE;
        i_cfg_data <= d_size;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAX_SENDERS;
        i_cfg_data <= d_max;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_RESEND_WAIT;
        i_cfg_data <= d_wait;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_n++;
    endtask

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            int gap;
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge i_clk); while (!m_fire);
        end
    end

    initial begin
        logic [15:0] v_node, v_size, v_max, v_wait;
        logic [63:0] now, step;
        int          rand_n, n_items, add_pct, step_lim;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ADD;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_NODE_ID;
        i_cfg_data    = '0;
        idle_on       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: empty poll, tie order, saturation, not-yet-due
        put_word(REQ_POLL, 32'd0, 16'd0, 48'd0);
        put_word(REQ_ADD, 32'd0, 16'hFFFF, 48'd0);
        put_word(REQ_ADD, 32'hFFFF_FFFF, 16'h0000, 48'd0);
        put_word(REQ_ADD, 32'd4, 16'h1234, 48'd0);
        put_word(REQ_ADD, 32'd1, 16'h0005, T_MAX);
        put_word(REQ_POLL, 32'd0, 16'd0, 48'd0);
        put_word(REQ_POLL, 32'd0, 16'd0, 48'd0);
        put_word(REQ_POLL, 32'd0, 16'd0, 48'd999);
        put_word(REQ_POLL, 32'hFFFF_FFFF, 16'hFFFF, T_MAX);
        put_word(REQ_POLL, 32'd0, 16'd0, T_MAX);
        put_word(REQ_POLL, 32'd0, 16'd0, T_MAX);
        // zero network size
        drain_queue();
        set_registers(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        put_word(REQ_ADD, 32'hFFFF_FFFF, 16'hAAAA, 48'd12345);
        put_word(REQ_POLL, 32'd0, 16'd0, 48'd12345);
        // largest distance and wait, near saturation
        drain_queue();
        set_registers(16'h0000, 16'h0100, 16'h0100, 16'hFFFF);
        put_word(REQ_ADD, 32'd1, 16'h5555, 48'hFFFF_FF00_0000);
        put_word(REQ_ADD, 32'd1, 16'h2222, T_MAX - 48'd100);
        put_word(REQ_POLL, 32'd0, 16'd0, T_MAX);
        put_word(REQ_POLL, 32'd0, 16'd0, T_MAX);
        // oversized network size, skip
        drain_queue();
        set_registers(16'd200, 16'hFFFF, 16'h0100, 16'h0000);
        put_word(REQ_ADD, 32'd300, 16'h0F0F, 48'd7);
        put_word(REQ_ADD, 32'd200, 16'hF0F0, 48'd7);
        put_word(REQ_POLL, 32'd0, 16'd0, T_MAX);
        // node id not below size
        drain_queue();
        set_registers(16'h00FF, 16'd7, 16'd2, 16'd1);
        put_word(REQ_ADD, 32'd3, 16'h0001, 48'd50);
        put_word(REQ_ADD, 32'd0, 16'h0002, 48'd50);
        put_word(REQ_ADD, 32'd1, 16'h0003, 48'd50);
        put_word(REQ_POLL, 32'd0, 16'd0, T_MAX);
        put_word(REQ_POLL, 32'd0, 16'd0, T_MAX);

        rand_n = 0;
        while (rand_n < 1900) begin
            drain_queue();
            v_node = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0:       v_size = 16'd0;
                1:       v_size = 16'd1;
                2:       v_size = 16'd256;
                3:       v_size = 16'($urandom_range(257, 511));
                4:       v_size = 16'($urandom);
                default: v_size = 16'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       v_max = 16'd0;
                1:       v_max = 16'd256;
                2:       v_max = 16'($urandom);
                3:       v_max = 16'd511;
                default: v_max = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 7))
                0:       v_wait = 16'd0;
                1:       v_wait = 16'hFFFF;
                2:       v_wait = 16'($urandom);
                default: v_wait = 16'($urandom_range(1, 200));
            endcase
            set_registers(v_node, v_size, v_max, v_wait);
            idle_on = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 5))
                0:       now = {16'd0, T_MAX} - 64'($urandom_range(0, 100000));
                1:       now = {$urandom, $urandom} & {16'd0, T_MAX};
                default: now = 64'($urandom_range(0, 1000));
            endcase
            add_pct  = $urandom_range(30, 90);
            n_items  = $urandom_range(40, 120);
            step_lim = int'(v_wait) * 3 + 20;
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 15) == 0)
                    put_word(REQ_POLL, $urandom, 16'($urandom), 48'({$urandom, $urandom}));
                else if ($urandom_range(1, 100) <= add_pct)
                    put_word(REQ_ADD, $urandom, 16'($urandom), now[47:0]);
                else
                    put_word(REQ_POLL, $urandom, 16'($urandom), now[47:0]);
                step = 64'($urandom_range(0, step_lim));
                if (now > {16'd0, T_MAX} - step) now = {16'd0, T_MAX};
                else now = now + step;
            end
            rand_n += n_items;
        end
        drain_queue();

        $display("Sent %0d words (%0d adds, %0d polls) across %0d register settings",
                 words_n, adds_n, polls_n, settings_n);
        $display("Seen %0d releases, %0d skipped adds, %0d full-queue drops",
                 released_n, skipped_n, dropped_n);
        if (fail_count == 0 && open_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### timed_resend_priority_queue.f
+incdir+rtl
rtl/trpq_pkg.sv
rtl/trpq_cell.sv
rtl/trpq_mod.sv
rtl/timed_resend_priority_queue.sv
rtl/trpq_chk.sv
tb/timed_resend_priority_queue_checker.sv
tb/timed_resend_priority_queue_test.sv
